/* design/kdd_pkg.sv */
// ----------------------------------------------------------------------------
// kdd_pkg: shared types and constants for the key debounce block
// Phase encoding, key indexes, result codes, register indexes and limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kdd_pkg;

  localparam int COUNT_WIDTH = 12;
  localparam int CFG_WIDTH   = 12;
  localparam int DEB_WIDTH   = 8;
  localparam int WIN_WIDTH   = 12;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  localparam count_t CNT_MAX = '1;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_LOCK1   = 4'd1,
    PH_RELEASE = 4'd2,
    PH_LOCK2   = 4'd3,
    PH_WINDOW  = 4'd4
  } phase_e;

  typedef logic [1:0] key_idx_t;
  localparam key_idx_t KEY_UP    = 2'd0;
  localparam key_idx_t KEY_LEFT  = 2'd1;
  localparam key_idx_t KEY_RIGHT = 2'd2;
  localparam key_idx_t KEY_DOWN  = 2'd3;

  typedef logic [2:0] code_t;
  localparam code_t CODE_UP     = 3'd1;
  localparam code_t CODE_LEFT   = 3'd2;
  localparam code_t CODE_RIGHT  = 3'd3;
  localparam code_t CODE_DOWN   = 3'd4;
  localparam code_t CODE_DOUBLE = 3'd5;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_DEBOUNCE = 1'b0;
  localparam reg_idx_t REG_WINDOW   = 1'b1;

  typedef struct packed {
    logic [DEB_WIDTH-1:0] debounce_ticks;
    logic [WIN_WIDTH-1:0] double_window_ticks;
  } kdd_cfg_t;

  // A limit above the counter range acts as the counter maximum.
  function automatic count_t clamp_limit(input logic [CFG_WIDTH-1:0] v);
    logic [CMP_WIDTH-1:0] v_ext;
    v_ext = CMP_WIDTH'(v);
    if (v_ext > CMP_WIDTH'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return COUNT_WIDTH'(v_ext);
  endfunction

  function automatic code_t code_of_key(input key_idx_t k);
    code_t c;
    case (k)
      KEY_UP:    c = CODE_UP;
      KEY_LEFT:  c = CODE_LEFT;
      KEY_RIGHT: c = CODE_RIGHT;
      default:   c = CODE_DOWN;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/kdd_key_if.sv */
// ----------------------------------------------------------------------------
// kdd_key_if: tick channel carrying the four button levels
// Valid/ready handshake; one transfer per tick item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kdd_key_if;
  logic valid;
  logic ready;
  logic key_up;
  logic key_left;
  logic key_right;
  logic key_down;

  modport source (output valid, output key_up, output key_left, output key_right,
                  output key_down, input ready);
  modport sink (input valid, input key_up, input key_left, input key_right,
                input key_down, output ready);
endinterface

`default_nettype wire

/* design/kdd_code_if.sv */
// ----------------------------------------------------------------------------
// kdd_code_if: result channel carrying the qualified key code
// Valid/ready handshake; one transfer per key event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kdd_code_if;
  logic       valid;
  logic       ready;
  logic [2:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

`default_nettype wire

/* design/key_debounce_double_click_top.sv */
// ----------------------------------------------------------------------------
// key_debounce_double_click_top: button debounce with up-key double press
// Qualifies presses of four buttons, one tick item at a time, into key codes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                 Handshake
//  key_i     in         key_up, key_left, key_right, key_down   valid/ready
//  code_o    out        key_code[2:0]                           valid/ready
//  cfg       in         cfg_idx_i[0:0], cfg_data_i[11:0]        cfg_we_i
//
//  One tick item is taken per clock while the input register is empty or the
//  output register can take a code; the item is registered, then processed
//  by the qualifier when it steps, and its key code (if any) is loaded into
//  the output register, from which code valid is driven.
//  A waiting code blocks processing only of the next buffered item; the input
//  register still takes one item while the code waits.
//  Reset restores debounce 50 ticks, window 300 ticks and the idle phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_double_click_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  kdd_key_if.sink                       key_i,
  kdd_code_if.source                    code_o,
  input  logic                          cfg_we_i,
  input  kdd_pkg::reg_idx_t             cfg_idx_i,
  input  logic [kdd_pkg::CFG_WIDTH-1:0] cfg_data_i
);
  import kdd_pkg::*;

  kdd_cfg_t   cfg;
  logic       in_valid_q;
  logic [3:0] in_keys_q;
  logic       out_valid_q;
  code_t      out_code_q;
  logic       out_free;
  logic       step;
  logic       res_valid;
  code_t      res_code;

  assign out_free    = !out_valid_q || code_o.ready;
  assign step        = in_valid_q && out_free;
  assign key_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (key_i.valid && key_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_i.valid && key_i.ready) begin
      in_keys_q <= {key_i.key_down, key_i.key_right, key_i.key_left, key_i.key_up};
    end
  end

  kdd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  kdd_qualifier u_qual (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .keys_i      (in_keys_q),
    .res_valid_o (res_valid),
    .res_code_o  (res_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_code_q <= res_code;
    end
  end

  assign code_o.valid    = out_valid_q;
  assign code_o.key_code = out_code_q;

endmodule

`default_nettype wire

/* design/kdd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// kdd_cfg_regs: configuration registers
// Holds the debounce length and the double-press window length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kdd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  kdd_pkg::reg_idx_t              cfg_idx_i,
  input  logic [kdd_pkg::CFG_WIDTH-1:0]  cfg_data_i,
  output kdd_pkg::kdd_cfg_t              cfg_o
);
  import kdd_pkg::*;

  kdd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE: cfg_d.debounce_ticks      = cfg_data_i[DEB_WIDTH-1:0];
        REG_WINDOW:   cfg_d.double_window_ticks = cfg_data_i[WIN_WIDTH-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks      <= DEB_WIDTH'(50);
      cfg_q.double_window_ticks <= WIN_WIDTH'(300);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* design/kdd_qualifier.sv */
// ----------------------------------------------------------------------------
// kdd_qualifier: press qualification state machine
// Lockout, release wait, second lockout and the up-key double-press window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kdd_qualifier (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kdd_pkg::kdd_cfg_t cfg_i,
  input  logic              step_i,
  input  logic [3:0]        keys_i,
  output logic              res_valid_o,
  output kdd_pkg::code_t    res_code_o
);
  import kdd_pkg::*;

  phase_e   phase_q, phase_d;
  key_idx_t held_q, held_d;
  count_t   tc_q, tc_d;
  logic     second_q, second_d;

  count_t   deb_lim;
  count_t   win_lim;
  logic     lock_done;
  logic     win_done;

  assign deb_lim   = clamp_limit(CFG_WIDTH'(cfg_i.debounce_ticks));
  assign win_lim   = clamp_limit(CFG_WIDTH'(cfg_i.double_window_ticks));
  assign lock_done = (tc_q >= deb_lim);
  assign win_done  = (tc_q >= win_lim);

  always_comb begin
    phase_d     = phase_q;
    held_d      = held_q;
    tc_d        = tc_q;
    second_d    = second_q;
    res_valid_o = 1'b0;
    res_code_o  = CODE_UP;
    if (step_i) begin
      unique case (phase_q)
        PH_LOCK1: begin
          // The release check runs in the same tick that ends the lockout.
          if (!lock_done) begin
            tc_d = tc_q + COUNT_WIDTH'(1);
          end else if (keys_i[held_q]) begin
            phase_d = PH_RELEASE;
          end else begin
            phase_d = PH_LOCK2;
            tc_d    = '0;
          end
        end
        PH_RELEASE: begin
          if (!keys_i[held_q]) begin
            phase_d = PH_LOCK2;
            tc_d    = '0;
          end
        end
        PH_LOCK2: begin
          if (!lock_done) begin
            tc_d = tc_q + COUNT_WIDTH'(1);
          end else if (held_q == KEY_UP && !second_q) begin
            // The window's first sample falls in this same tick.
            if (win_lim == '0) begin
              res_valid_o = 1'b1;
              res_code_o  = CODE_UP;
              phase_d     = PH_IDLE;
              tc_d        = '0;
            end else if (keys_i[KEY_UP]) begin
              second_d = 1'b1;
              held_d   = KEY_UP;
              phase_d  = PH_LOCK1;
              tc_d     = '0;
            end else begin
              phase_d = PH_WINDOW;
              tc_d    = COUNT_WIDTH'(1);
            end
          end else begin
            res_valid_o = 1'b1;
            res_code_o  = second_q ? CODE_DOUBLE : code_of_key(held_q);
            second_d    = 1'b0;
            phase_d     = PH_IDLE;
            tc_d        = '0;
          end
        end
        PH_WINDOW: begin
          if (win_done) begin
            res_valid_o = 1'b1;
            res_code_o  = CODE_UP;
            phase_d     = PH_IDLE;
            tc_d        = '0;
          end else if (keys_i[KEY_UP]) begin
            second_d = 1'b1;
            held_d   = KEY_UP;
            phase_d  = PH_LOCK1;
            tc_d     = '0;
          end else begin
            tc_d = tc_q + COUNT_WIDTH'(1);
          end
        end
        default: begin
          phase_d  = PH_IDLE;
          second_d = 1'b0;
          if (keys_i != 4'b0000) begin
            phase_d = PH_LOCK1;
            tc_d    = '0;
            if (keys_i[KEY_UP]) begin
              held_d = KEY_UP;
            end else if (keys_i[KEY_LEFT]) begin
              held_d = KEY_LEFT;
            end else if (keys_i[KEY_RIGHT]) begin
              held_d = KEY_RIGHT;
            end else begin
              held_d = KEY_DOWN;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      held_q   <= KEY_UP;
      tc_q     <= '0;
      second_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      held_q   <= held_d;
      tc_q     <= tc_d;
      second_q <= second_d;
    end
  end

  // A pending second press always belongs to the up key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> held_q == KEY_UP)
    else $error("second press flagged for a key other than up");

  // The double-press code needs the second press flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_code_o == CODE_DOUBLE) |-> second_q)
    else $error("double code without a second press");

  // Every result returns the machine to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> phase_q == PH_IDLE)
    else $error("phase not idle after a result");

  // While the watched key stays down the release wait holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_RELEASE && keys_i[held_q]) |=> phase_q == PH_RELEASE)
    else $error("release wait left while key held");

  // A running first lockout advances its counter by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_LOCK1 && !lock_done)
      |=> tc_q == $past(tc_q) + COUNT_WIDTH'(1))
    else $error("lockout counter did not advance");

endmodule

`default_nettype wire
